// ----- sv/sidt_pkg.sv -----
// Shared types and constants for the signed integer to decimal text unit.
// Holds the microcode word layout, step codes, the datapath status group and ASCII codes.
// No dependencies.
package sidt_pkg;

    // Sequencer step address
    typedef logic [2:0] step_t;

    localparam int    NUM_STEPS    = 8;
    localparam step_t STEP_IDLE    = 3'd0;
    localparam step_t STEP_SIGN    = 3'd1;
    localparam step_t STEP_DABBLE  = 3'd2;
    localparam step_t STEP_NORM    = 3'd3;
    localparam step_t STEP_PADSET  = 3'd4;
    localparam step_t STEP_PAD     = 3'd5;
    localparam step_t STEP_DIGIT   = 3'd6;
    localparam step_t STEP_TERM    = 3'd7;

    // Datapath operation selected by the control word
    typedef enum logic [2:0] {
        OP_IDLE,
        OP_SIGN,
        OP_DABBLE,
        OP_NORM,
        OP_PADSET,
        OP_PAD,
        OP_DIGIT,
        OP_TERM
    } op_t;

    // Jump condition: taken jumps go to the target, else fall through
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_WAIT_START,
        COND_BITS_MORE,
        COND_NORM_MORE,
        COND_PAD_MORE,
        COND_DIGIT_MORE
    } cond_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ucode_t;

    // Loop flags reported by the datapath to the sequencer
    typedef struct packed {
        logic bits_more;
        logic norm_more;
        logic pad_more;
        logic digit_more;
    } dp_status_t;

    // ASCII codes
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

endpackage

// ----- sv/sidt_ucode_rom.sv -----
// Microcode program store for the signed integer to decimal text unit.
// One control word per sequencer step. Depends on sidt_pkg.
module sidt_ucode_rom (
    input  sidt_pkg::step_t  step,
    output sidt_pkg::ucode_t word
);
    import sidt_pkg::*;

    // Program: wait, sign, convert, strip leading zeros, pad, digits, terminator
    localparam ucode_t UCODE [0:NUM_STEPS-1] = '{
        '{op: OP_IDLE,   cond: COND_WAIT_START, target: STEP_IDLE},
        '{op: OP_SIGN,   cond: COND_NEXT,       target: STEP_IDLE},
        '{op: OP_DABBLE, cond: COND_BITS_MORE,  target: STEP_DABBLE},
        '{op: OP_NORM,   cond: COND_NORM_MORE,  target: STEP_NORM},
        '{op: OP_PADSET, cond: COND_NEXT,       target: STEP_IDLE},
        '{op: OP_PAD,    cond: COND_PAD_MORE,   target: STEP_PAD},
        '{op: OP_DIGIT,  cond: COND_DIGIT_MORE, target: STEP_DIGIT},
        '{op: OP_TERM,   cond: COND_ALWAYS,     target: STEP_IDLE}
    };

    // Look up the control word for the current step
    assign word = UCODE[step];

endmodule

// ----- sv/sidt_datapath.sv -----
// Datapath of the signed integer to decimal text unit: operand capture,
// shift-and-add-3 binary to BCD, digit normalize and character output.
// Depends on sidt_pkg.
module sidt_datapath #(
    parameter int VALUE_BITS    = 64,
    parameter int MAX_PRECISION = 62
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  sidt_pkg::op_t          op,
    input  logic                   start,
    input  logic signed [63:0]     value,
    input  logic                   force_plus,
    input  logic                   space_sign,
    input  logic signed [6:0]      min_digits,
    output sidt_pkg::dp_status_t   status,
    output logic                   strobe,
    output logic [7:0]             text_char,
    output logic                   last
);
    import sidt_pkg::*;

    localparam int BCD_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int BCD_BITS   = 4 * BCD_DIGITS;
    localparam int CNT_W      = $clog2(VALUE_BITS + 1);
    localparam int DC_W       = $clog2(BCD_DIGITS + 1);
    localparam int PREC_W     = $clog2(MAX_PRECISION + 1);
    localparam int CMP_W      = (PREC_W > DC_W) ? PREC_W : DC_W;

    // Control state
    logic [CNT_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [DC_W-1:0]       dc_reg, dc_next;
    logic [PREC_W-1:0]     pad_reg, pad_next;
    logic                  strobe_reg, strobe_next;

    // Payload state
    logic [VALUE_BITS-1:0] mag_reg, mag_next;
    logic [BCD_BITS-1:0]   bcd_reg, bcd_next;
    logic [PREC_W-1:0]     prec_reg, prec_next;
    logic                  has_prec_reg, has_prec_next;
    logic                  zero_reg, zero_next;
    logic                  skip_reg, skip_next;
    logic                  sign_en_reg, sign_en_next;
    logic [7:0]            sign_char_reg, sign_char_next;
    logic [7:0]            char_reg, char_next;
    logic                  last_reg, last_next;

    logic [VALUE_BITS-1:0] in_val;
    logic                  in_neg;
    logic [BCD_BITS-1:0]   bcd_adj;
    logic [3:0]            top_digit;

    assign in_val    = value[VALUE_BITS-1:0];
    assign in_neg    = in_val[VALUE_BITS-1];
    assign top_digit = bcd_reg[BCD_BITS-1 -: 4];

    // Add 3 to every digit of 5 or more before the shift
    always_comb
    begin
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            if (bcd_reg[4*i +: 4] >= 4'd5)
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            else
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
        end
    end

    // Report loop conditions
    assign status.bits_more  = (bit_cnt_reg > CNT_W'(1));
    assign status.norm_more  = (top_digit == 4'h0) && (dc_reg > DC_W'(1));
    assign status.pad_more   = (pad_reg > PREC_W'(1));
    assign status.digit_more = (dc_reg > DC_W'(1));

    // Next-state logic per operation
    always_comb
    begin
        bit_cnt_next   = bit_cnt_reg;
        dc_next        = dc_reg;
        pad_next       = pad_reg;
        strobe_next    = 1'b0;
        mag_next       = mag_reg;
        bcd_next       = bcd_reg;
        prec_next      = prec_reg;
        has_prec_next  = has_prec_reg;
        zero_next      = zero_reg;
        skip_next      = skip_reg;
        sign_en_next   = sign_en_reg;
        sign_char_next = sign_char_reg;
        char_next      = char_reg;
        last_next      = 1'b0;

        case (op)
            OP_IDLE:
            begin
                // Capture the transaction
                if (start)
                begin
                    mag_next      = in_neg ? (~in_val + VALUE_BITS'(1)) : in_val;
                    bcd_next      = '0;
                    bit_cnt_next  = CNT_W'(VALUE_BITS);
                    dc_next       = DC_W'(BCD_DIGITS);
                    has_prec_next = ~min_digits[6];
                    if (7'(min_digits[5:0]) > 7'(MAX_PRECISION))
                        prec_next = PREC_W'(MAX_PRECISION);
                    else
                        prec_next = PREC_W'(min_digits[5:0]);
                    zero_next     = (in_val == '0);
                    if (in_neg)
                    begin
                        sign_en_next   = 1'b1;
                        sign_char_next = CHAR_MINUS;
                    end
                    else if (force_plus)
                    begin
                        sign_en_next   = 1'b1;
                        sign_char_next = CHAR_PLUS;
                    end
                    else
                    begin
                        sign_en_next   = space_sign;
                        sign_char_next = CHAR_SPACE;
                    end
                end
            end
            OP_SIGN:
            begin
                strobe_next = sign_en_reg;
                char_next   = sign_char_reg;
            end
            OP_DABBLE:
            begin
                // Shift one magnitude bit into the BCD register
                bcd_next     = {bcd_adj[BCD_BITS-2:0], mag_reg[VALUE_BITS-1]};
                mag_next     = {mag_reg[VALUE_BITS-2:0], 1'b0};
                bit_cnt_next = bit_cnt_reg - CNT_W'(1);
            end
            OP_NORM:
            begin
                // Drop a leading zero digit, keep at least one
                if (status.norm_more)
                begin
                    bcd_next = {bcd_reg[BCD_BITS-5:0], 4'h0};
                    dc_next  = dc_reg - DC_W'(1);
                end
            end
            OP_PADSET:
            begin
                if (has_prec_reg && (CMP_W'(prec_reg) > CMP_W'(dc_reg)))
                    pad_next = PREC_W'(CMP_W'(prec_reg) - CMP_W'(dc_reg));
                else
                    pad_next = '0;
                skip_next = has_prec_reg && (prec_reg == '0) && zero_reg;
            end
            OP_PAD:
            begin
                if (pad_reg != '0)
                begin
                    strobe_next = 1'b1;
                    char_next   = CHAR_ZERO;
                    pad_next    = pad_reg - PREC_W'(1);
                end
            end
            OP_DIGIT:
            begin
                // Emit the most significant digit and advance
                strobe_next = ~skip_reg;
                char_next   = CHAR_ZERO + {4'h0, top_digit};
                bcd_next    = {bcd_reg[BCD_BITS-5:0], 4'h0};
                dc_next     = dc_reg - DC_W'(1);
            end
            OP_TERM:
            begin
                strobe_next = 1'b1;
                char_next   = CHAR_NUL;
                last_next   = 1'b1;
            end
            default:
            begin
                strobe_next = 1'b0;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_cnt_reg <= '0;
            dc_reg      <= '0;
            pad_reg     <= '0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            bit_cnt_reg <= bit_cnt_next;
            dc_reg      <= dc_next;
            pad_reg     <= pad_next;
            strobe_reg  <= strobe_next;
        end
    end

    // Hold payload state
    always_ff @(posedge clk)
    begin
        mag_reg       <= mag_next;
        bcd_reg       <= bcd_next;
        prec_reg      <= prec_next;
        has_prec_reg  <= has_prec_next;
        zero_reg      <= zero_next;
        skip_reg      <= skip_next;
        sign_en_reg   <= sign_en_next;
        sign_char_reg <= sign_char_next;
        char_reg      <= char_next;
        last_reg      <= last_next;
    end

    assign strobe    = strobe_reg;
    assign text_char = char_reg;
    assign last      = last_reg;

endmodule

// ----- sv/signed_int_to_decimal_text_unit.sv -----
// Top level of the signed integer to decimal text unit: microcode sequencer
// over sidt_ucode_rom and sidt_datapath. Depends on sidt_pkg.
//
//  Channel | Ports                                          | Handshake
//  --------+------------------------------------------------+------------------------
//  input   | value, force_plus, space_sign, min_digits      | start high, busy low
//  result  | text_char, last                                | strobe, one cycle
//
// One transaction keeps busy high from the sign step through the terminator
// step, and no new transaction is taken until busy falls. The shift-and-add-3
// loop takes one magnitude bit per cycle; the sign character leaves before it,
// pad zeros and digits after it. Reset returns the sequencer to its wait
// step. Results cannot be stalled; the terminator with last set is shown as
// busy falls.
module signed_int_to_decimal_text_unit #(
    parameter int VALUE_BITS    = 64,
    parameter int MAX_PRECISION = 62
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [63:0] value,
    input  logic               force_plus,
    input  logic               space_sign,
    input  logic signed [6:0]  min_digits,
    output logic               strobe,
    output logic [7:0]         text_char,
    output logic               last
);
    import sidt_pkg::*;

    step_t      pc_reg, pc_next;
    ucode_t     ctrl;
    dp_status_t status;
    logic       take;

    sidt_ucode_rom u_rom (
        .step (pc_reg),
        .word (ctrl)
    );

    sidt_datapath #(
        .VALUE_BITS    (VALUE_BITS),
        .MAX_PRECISION (MAX_PRECISION)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (ctrl.op),
        .start      (start),
        .value      (value),
        .force_plus (force_plus),
        .space_sign (space_sign),
        .min_digits (min_digits),
        .status     (status),
        .strobe     (strobe),
        .text_char  (text_char),
        .last       (last)
    );

    // Evaluate the jump condition
    always_comb
    begin
        case (ctrl.cond)
            COND_NEXT:       take = 1'b0;
            COND_ALWAYS:     take = 1'b1;
            COND_WAIT_START: take = ~start;
            COND_BITS_MORE:  take = status.bits_more;
            COND_NORM_MORE:  take = status.norm_more;
            COND_PAD_MORE:   take = status.pad_more;
            COND_DIGIT_MORE: take = status.digit_more;
            default:         take = 1'b0;
        endcase
        pc_next = take ? ctrl.target : pc_reg + step_t'(1);
    end

    // Advance the step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pc_reg <= STEP_IDLE;
        else
            pc_reg <= pc_next;
    end

    assign busy = (pc_reg != STEP_IDLE);

`ifndef NO_ASSERTIONS
    // An accepted transaction makes the unit busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    // The terminator arrives exactly as the unit goes idle
    a_term_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |-> !busy)
        else $error("terminator while still busy");

    // Non-terminal characters only appear while busy
    a_char_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |-> busy)
        else $error("character emitted while idle");

    // The terminator carries a NUL and no other result does
    a_term_nul: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> ((text_char == CHAR_NUL) == last))
        else $error("terminator and NUL character disagree");
`endif

endmodule
